@@ src/assert_macros.svh @@
// Assertion macros shared by the walker RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/fltw_pkg.sv @@
// Shared types, constants and helper functions of the page table walker.
// No dependencies; used by the interfaces and all walker modules.
package fltw_pkg;

  localparam int TABLE_PAGES_DEFAULT = 64;
  localparam int IDX_W = 9;
  localparam int VA_W = 48;
  localparam int DESC_W = 64;
  localparam int DPAGE_W = 36;
  localparam int OFFSET_W = 12;
  localparam int ROOT_W = 6;
  localparam int LEVEL_W = 2;
  localparam int CFG_INDEX_W = 2;
  localparam logic [DESC_W-1:0] ATTR_RESET = 64'h00E8_0000_0000_0F43;
  localparam logic [1:0] DESC_VALID = 2'b11;

  typedef enum logic [1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_MAP = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_UNUSABLE = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROOT_PAGE = 2'd0,
    CFG_LEAF_ATTR = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_READ
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [1:0] status;
    logic [VA_W-1:0] phys_addr;
    logic [LEVEL_W-1:0] fault_level;
    logic [DESC_W-1:0] entry_data;
    logic leaf_written;
  } result_t;

  function automatic logic usable(input logic [DESC_W-1:0] d);
    return (d[1:0] == DESC_VALID) && (d[VA_W-1:OFFSET_W] != '0);
  endfunction

  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ src/fltw_if.sv @@
// Handshake channel interfaces for requests, results and configuration writes.
// Depends on fltw_pkg for field widths.
interface fltw_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [fltw_pkg::VA_W-1:0] virt_addr;
  logic [fltw_pkg::VA_W-1:0] target_phys;
  logic [fltw_pkg::ROOT_W-1:0] table_page;
  logic [fltw_pkg::IDX_W-1:0] entry_index;
  logic [fltw_pkg::DESC_W-1:0] entry_value;

  modport source (output valid, req_type, virt_addr, target_phys, table_page,
                  entry_index, entry_value, input ready);
  modport sink (input valid, req_type, virt_addr, target_phys, table_page,
                entry_index, entry_value, output ready);
endinterface

interface fltw_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [fltw_pkg::VA_W-1:0] phys_addr;
  logic [fltw_pkg::LEVEL_W-1:0] fault_level;
  logic [fltw_pkg::DESC_W-1:0] entry_data;
  logic leaf_written;

  modport source (output valid, status, phys_addr, fault_level, entry_data,
                  leaf_written, input ready);
  modport sink (input valid, status, phys_addr, fault_level, entry_data,
                leaf_written, output ready);
endinterface

interface fltw_cfg_if;
  logic valid;
  logic ready;
  logic [fltw_pkg::CFG_INDEX_W-1:0] index;
  logic [fltw_pkg::DESC_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/fltw_store.sv @@
// Descriptor store: one synchronous memory with a write port and a registered read port.
// Depends on fltw_pkg for the control struct and the descriptor width.
module fltw_store #(
  parameter int DEPTH = fltw_pkg::TABLE_PAGES_DEFAULT * (2 ** fltw_pkg::IDX_W),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  fltw_pkg::mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0]           addr,
  input  logic [fltw_pkg::DESC_W-1:0] wdata,
  output logic [fltw_pkg::DESC_W-1:0] rdata
);

  logic [fltw_pkg::DESC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ src/fltw_walker.sv @@
// Request sequencer: walks the four table levels, serves entry reads and writes,
// and holds one finished result. Depends on fltw_pkg and fltw_req_if.
module fltw_walker #(
  parameter int TABLE_PAGES = fltw_pkg::TABLE_PAGES_DEFAULT,
  parameter int ADDR_W = $clog2(TABLE_PAGES) + fltw_pkg::IDX_W
) (
  input  logic                        clk,
  input  logic                        rst,
  fltw_req_if.sink                    req,
  input  logic [fltw_pkg::ROOT_W-1:0] root_page,
  input  logic [fltw_pkg::DESC_W-1:0] leaf_attr,
  output fltw_pkg::mem_ctl_t          mem_ctl,
  output logic [ADDR_W-1:0]           mem_addr,
  output logic [fltw_pkg::DESC_W-1:0] mem_wdata,
  input  logic [fltw_pkg::DESC_W-1:0] mem_rdata,
  output logic                        done_valid,
  output fltw_pkg::result_t           done,
  input  logic                        done_pop
);

  localparam int PAGE_W = ADDR_W - fltw_pkg::IDX_W;
  localparam logic [fltw_pkg::DPAGE_W-1:0] PAGE_LIMIT = fltw_pkg::DPAGE_W'(TABLE_PAGES);

  fltw_pkg::state_t state, state_next;
  logic [fltw_pkg::LEVEL_W-1:0] lvl, lvl_next;
  logic [ADDR_W-1:0] addr_q, addr_next;
  fltw_pkg::req_type_t type_q;
  logic [fltw_pkg::VA_W-1:0] va_q;
  logic [fltw_pkg::DPAGE_W-1:0] tp_q;
  logic finish;
  fltw_pkg::result_t res_next;
  logic accept;
  logic [fltw_pkg::DPAGE_W-1:0] root_ext, req_page_ext, next_page;
  logic [fltw_pkg::DESC_W-1:0] d;

  assign req.ready = (state == fltw_pkg::S_IDLE) && !done_valid;
  assign accept = req.valid && req.ready;
  assign root_ext = fltw_pkg::DPAGE_W'(root_page);
  assign req_page_ext = fltw_pkg::DPAGE_W'(req.table_page);
  assign d = mem_rdata;
  assign next_page = d[fltw_pkg::VA_W-1:fltw_pkg::OFFSET_W];
  assign mem_addr = addr_next;

  always_comb begin
    state_next = state;
    lvl_next = lvl;
    addr_next = addr_q;
    mem_ctl = '0;
    mem_wdata = leaf_attr | {16'b0, tp_q, 12'b0};
    finish = 1'b0;
    res_next = '0;
    case (state)
      fltw_pkg::S_IDLE: begin
        if (accept) begin
          case (fltw_pkg::req_type_t'(req.req_type))
            fltw_pkg::REQ_TRANSLATE, fltw_pkg::REQ_MAP: begin
              if (root_ext >= PAGE_LIMIT) begin
                finish = 1'b1;
                res_next.status = fltw_pkg::ST_RANGE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                addr_next = {root_ext[PAGE_W-1:0], fltw_pkg::level_index(req.virt_addr, 2'd0)};
                lvl_next = '0;
                state_next = fltw_pkg::S_WALK;
              end
            end
            fltw_pkg::REQ_WRITE: begin
              finish = 1'b1;
              if (req_page_ext >= PAGE_LIMIT) begin
                res_next.status = fltw_pkg::ST_RANGE;
              end else begin
                mem_ctl.wr_en = 1'b1;
                addr_next = {req_page_ext[PAGE_W-1:0], req.entry_index};
                mem_wdata = req.entry_value;
              end
            end
            default: begin
              if (req_page_ext >= PAGE_LIMIT) begin
                finish = 1'b1;
                res_next.status = fltw_pkg::ST_RANGE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                addr_next = {req_page_ext[PAGE_W-1:0], req.entry_index};
                state_next = fltw_pkg::S_READ;
              end
            end
          endcase
        end
      end
      fltw_pkg::S_WALK: begin
        if (lvl != 2'd3) begin
          if (!fltw_pkg::usable(d)) begin
            finish = 1'b1;
            res_next.status = fltw_pkg::ST_UNUSABLE;
            res_next.fault_level = lvl;
            state_next = fltw_pkg::S_IDLE;
          end else if (next_page >= PAGE_LIMIT) begin
            finish = 1'b1;
            res_next.status = fltw_pkg::ST_RANGE;
            res_next.fault_level = lvl + 2'd1;
            state_next = fltw_pkg::S_IDLE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            addr_next = {next_page[PAGE_W-1:0], fltw_pkg::level_index(va_q, lvl + 2'd1)};
            lvl_next = lvl + 2'd1;
          end
        end else begin
          finish = 1'b1;
          state_next = fltw_pkg::S_IDLE;
          if (type_q == fltw_pkg::REQ_TRANSLATE) begin
            if (fltw_pkg::usable(d)) begin
              res_next.phys_addr = {next_page, va_q[fltw_pkg::OFFSET_W-1:0]};
            end else begin
              res_next.status = fltw_pkg::ST_UNUSABLE;
              res_next.fault_level = lvl;
            end
          end else begin
            res_next.entry_data = d;
            if (!fltw_pkg::usable(d)) begin
              mem_ctl.wr_en = 1'b1;
              res_next.leaf_written = 1'b1;
            end
          end
        end
      end
      fltw_pkg::S_READ: begin
        finish = 1'b1;
        res_next.entry_data = d;
        state_next = fltw_pkg::S_IDLE;
      end
      default: begin
        state_next = fltw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fltw_pkg::S_IDLE;
      done_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        done_valid <= 1'b1;
      end else if (done_pop) begin
        done_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl <= lvl_next;
    addr_q <= addr_next;
    if (finish) begin
      done <= res_next;
    end
    if (accept) begin
      type_q <= fltw_pkg::req_type_t'(req.req_type);
      va_q <= req.virt_addr;
      tp_q <= req.target_phys[fltw_pkg::VA_W-1:fltw_pkg::OFFSET_W];
    end
  end

endmodule

@@ src/four_level_page_table_walker.sv @@
// Four-level page table walker with a local descriptor store of TABLE_PAGES pages
// of 512 descriptors. Translate and map read one descriptor per level from a single
// memory with a registered read port; their result takes four dependent reads, the
// leaf write of a map in the last of them, and the result register. Write entry needs
// no read; read entry needs one. One request is in flight at a time; a finished result
// waits in a holding register and the output register, so the next request beat is
// taken while the previous result is unclaimed. The store needs no clearing after reset
// only if every entry is written before it is read; the user must ensure it, the block does not.
module four_level_page_table_walker #(
  parameter int TABLE_PAGES = fltw_pkg::TABLE_PAGES_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  fltw_cfg_if.sink cfg,
  fltw_req_if.sink req,
  fltw_rsp_if.source rsp
);

`include "assert_macros.svh"

  localparam int DEPTH = TABLE_PAGES * (2 ** fltw_pkg::IDX_W);
  localparam int ADDR_W = $clog2(TABLE_PAGES) + fltw_pkg::IDX_W;

  logic [fltw_pkg::ROOT_W-1:0] root_page;
  logic [fltw_pkg::DESC_W-1:0] leaf_attr;
  fltw_pkg::mem_ctl_t mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [fltw_pkg::DESC_W-1:0] mem_wdata, mem_rdata;
  logic done_valid, done_pop;
  fltw_pkg::result_t done, out_res;
  logic out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_page <= '0;
      leaf_attr <= fltw_pkg::ATTR_RESET;
    end else if (cfg.valid) begin
      case (fltw_pkg::cfg_index_t'(cfg.index))
        fltw_pkg::CFG_ROOT_PAGE: root_page <= cfg.data[fltw_pkg::ROOT_W-1:0];
        fltw_pkg::CFG_LEAF_ATTR: leaf_attr <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  fltw_walker #(
    .TABLE_PAGES(TABLE_PAGES),
    .ADDR_W(ADDR_W)
  ) u_walker (
    .clk(clk),
    .rst(rst),
    .req(req),
    .root_page(root_page),
    .leaf_attr(leaf_attr),
    .mem_ctl(mem_ctl),
    .mem_addr(mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata),
    .done_valid(done_valid),
    .done(done),
    .done_pop(done_pop)
  );

  fltw_store #(
    .DEPTH(DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk(clk),
    .ctl(mem_ctl),
    .addr(mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign done_pop = done_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_pop) begin
      out_res <= done;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_res.status;
  assign rsp.phys_addr = out_res.phys_addr;
  assign rsp.fault_level = out_res.fault_level;
  assign rsp.entry_data = out_res.entry_data;
  assign rsp.leaf_written = out_res.leaf_written;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `ASSERT_NEXT(a_no_read_after_write, clk, rst, mem_ctl.wr_en, !mem_ctl.rd_en)
  `ASSERT_IMPLIES(a_fault_clean, clk, rst, out_valid && (out_res.status != fltw_pkg::ST_OK), (out_res.entry_data == '0) && !out_res.leaf_written)

endmodule
